>>> design/glos_pkg.sv
// Shared types and constants for the grid line-of-sight block.
package glos_pkg;

    // Walk coordinates run from -1 up to 255; one sign bit over nine magnitude bits holds them.
    localparam int COORD_W = 10;

    // Width that holds any grid dimension, up to 8191.
    localparam int LIM_W = 13;

    // Operation codes carried on the op field.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // One cell reference handed to the address unit.
    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_cell;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_LOOP,
        S_WAIT,
        S_CHK2,
        S_DONE
    } t_state;

    // Which cell check a pending map read belongs to.
    typedef enum logic [1:0] {
        K_ENTER,
        K_INNER,
        K_PAIR_HI,
        K_PAIR_LO
    } t_kind;

endpackage

>>> design/grid_line_of_sight_top.sv
// Top level of the grid line-of-sight block: obstacle map and line walk sequencer.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------------------
//  input   | i_valid / o_stall  | i_op, i_cell_row, i_cell_col, i_cell_blocked,
//          |                    | i_from_row, i_from_col, i_to_row, i_to_col
//  output  | o_valid / i_stall  | o_visible (one item per query, none per write)
//
// A write item is taken while idle. A query walks the line step by step along the major axis;
// a step issues one map read per cell it checks, an entered cell adds the S_CHK2 state, and
// the single read port of the map serialises its two checks.
// After reset the map is cleared one cell a cycle, every cell of the grid, with o_stall high.
// A finished result waits in the output register while i_stall is high; the next item is
// accepted meanwhile, and a later query holds in its final state until the register frees.
module grid_line_of_sight_top
    import glos_pkg::*;
#(
    parameter int GRID_H = 256,
    parameter int GRID_W = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic [7:0] i_cell_row,
    input  logic [7:0] i_cell_col,
    input  logic       i_cell_blocked,
    input  logic [7:0] i_from_row,
    input  logic [7:0] i_from_col,
    input  logic [7:0] i_to_row,
    input  logic [7:0] i_to_col,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_visible
);

    localparam int DEPTH = GRID_H * GRID_W;
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state r_state, n_state;
    t_kind  r_kind,  n_kind;

    logic [AW-1:0] r_clr_cnt;
    logic [7:0]    r_fr, r_fc, r_tr, r_tc;
    logic          r_swap;
    logic [7:0]    r_maj, n_maj;
    logic [7:0]    r_min, n_min;
    logic [7:0]    r_tmaj;
    logic [7:0]    r_dmaj, r_dmin;
    logic          r_maj_neg, r_min_neg;
    logic [8:0]    r_acc, n_acc;
    logic          r_res, n_res;
    logic          r_oob;
    logic          r_out_valid;
    logic          r_visible;

    logic [7:0] w_dr, w_dc;
    logic       w_r_neg, w_c_neg, w_horiz;
    logic [8:0] w_acc_sum, w_sec_acc;
    logic       w_enter, w_at_end, w_sec_inner, w_sec_pair;
    logic       w_blocked, w_out_free, w_in_acc;
    logic [7:0] w_maj_step, w_min_step;
    t_coord     w_maj_x, w_min_x, w_pmaj, w_pmin;
    t_cell      w_cell;
    logic [AW-1:0] w_cell_addr, w_waddr;
    logic       w_cell_oob;
    logic       w_we, w_wdata, w_rd_bit;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_visible  = r_visible;

    // Line set-up from the captured end points: distances, directions and major axis.
    assign w_r_neg = (r_tr < r_fr);
    assign w_c_neg = (r_tc < r_fc);
    assign w_dr    = w_r_neg ? (r_fr - r_tr) : (r_tr - r_fr);
    assign w_dc    = w_c_neg ? (r_fc - r_tc) : (r_tc - r_fc);
    assign w_horiz = (w_dc >= w_dr);

    // Decisions of one walk step.
    assign w_acc_sum   = r_acc + {1'b0, r_dmin};
    assign w_enter     = (w_acc_sum >= {1'b0, r_dmaj});
    assign w_at_end    = (r_maj == r_tmaj);
    assign w_sec_acc   = (r_state == S_LOOP) ? w_acc_sum : r_acc;
    assign w_sec_inner = (w_sec_acc != '0);
    assign w_sec_pair  = (r_dmin == '0);
    assign w_blocked   = r_oob | w_rd_bit;
    assign w_maj_step  = r_maj_neg ? (r_maj - 8'd1) : (r_maj + 8'd1);
    assign w_min_step  = r_min_neg ? (r_min - 8'd1) : (r_min + 8'd1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc && i_op == OP_QUERY) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_LOOP;
            end
            S_LOOP: begin
                if (w_at_end) begin
                    n_state = S_DONE;
                end else if (w_enter || w_sec_inner || w_sec_pair) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                case (r_kind)
                    K_ENTER:   n_state = w_blocked ? S_DONE : S_CHK2;
                    K_PAIR_HI: n_state = w_blocked ? S_WAIT : S_LOOP;
                    default:   n_state = w_blocked ? S_DONE : S_LOOP;
                endcase
            end
            S_CHK2: begin
                n_state = (w_sec_inner || w_sec_pair) ? S_WAIT : S_LOOP;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Walk updates, map writes and the check to issue.
    always_comb begin
        n_acc   = r_acc;
        n_maj   = r_maj;
        n_min   = r_min;
        n_kind  = r_kind;
        n_res   = r_res;
        w_we    = 1'b0;
        w_wdata = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_IDLE: begin
                if (w_in_acc && i_op == OP_WRITE) begin
                    w_we    = !w_cell_oob;
                    w_wdata = i_cell_blocked;
                end
            end
            S_LOOP: begin
                if (w_at_end) begin
                    n_res = 1'b1;
                end else begin
                    n_acc = w_acc_sum;
                    if (w_enter) begin
                        n_kind = K_ENTER;
                    end else if (w_sec_inner) begin
                        n_kind = K_INNER;
                    end else if (w_sec_pair) begin
                        n_kind = K_PAIR_HI;
                    end else begin
                        n_maj = w_maj_step;
                    end
                end
            end
            S_WAIT: begin
                case (r_kind)
                    K_ENTER: begin
                        if (w_blocked) begin
                            n_res = 1'b0;
                        end else begin
                            n_min = w_min_step;
                            n_acc = r_acc - {1'b0, r_dmaj};
                        end
                    end
                    K_PAIR_HI: begin
                        if (w_blocked) begin
                            n_kind = K_PAIR_LO;
                        end else begin
                            n_maj = w_maj_step;
                        end
                    end
                    default: begin
                        if (w_blocked) begin
                            n_res = 1'b0;
                        end else begin
                            n_maj = w_maj_step;
                        end
                    end
                endcase
            end
            S_CHK2: begin
                if (w_sec_inner) begin
                    n_kind = K_INNER;
                end else if (w_sec_pair) begin
                    n_kind = K_PAIR_HI;
                end else begin
                    n_maj = w_maj_step;
                end
            end
            default: begin
            end
        endcase
    end

    // Cell to look up: the written cell when idle, otherwise the check being issued.
    assign w_maj_x = t_coord'(r_maj);
    assign w_min_x = t_coord'(r_min);
    assign w_pmaj  = w_maj_x - t_coord'(r_maj_neg);

    always_comb begin
        case (n_kind)
            K_PAIR_HI: w_pmin = w_min_x;
            K_PAIR_LO: w_pmin = w_min_x - t_coord'(1);
            default:   w_pmin = w_min_x - t_coord'(r_min_neg);
        endcase
        if (r_state == S_IDLE) begin
            w_cell.row = t_coord'(i_cell_row);
            w_cell.col = t_coord'(i_cell_col);
        end else begin
            w_cell.row = r_swap ? w_pmaj : w_pmin;
            w_cell.col = r_swap ? w_pmin : w_pmaj;
        end
    end

    glos_cell_idx #(
        .GRID_H (GRID_H),
        .GRID_W (GRID_W),
        .AW     (AW)
    ) u_cell_idx (
        .i_cell (w_cell),
        .o_addr (w_cell_addr),
        .o_oob  (w_cell_oob)
    );

    assign w_waddr = (r_state == S_CLEAR) ? r_clr_cnt : w_cell_addr;

    glos_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_cell_addr),
        .o_rdata (w_rd_bit)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (w_out_free) begin
                r_out_valid <= (r_state == S_DONE);
            end
        end
    end

    // Walk and result registers.
    always_ff @(posedge i_clk) begin
        r_oob <= w_cell_oob;
        r_res <= n_res;
        r_kind <= n_kind;
        if (w_in_acc && i_op == OP_QUERY) begin
            r_fr <= i_from_row;
            r_fc <= i_from_col;
            r_tr <= i_to_row;
            r_tc <= i_to_col;
        end
        if (r_state == S_SETUP) begin
            r_swap    <= !w_horiz;
            r_maj     <= w_horiz ? r_fc : r_fr;
            r_tmaj    <= w_horiz ? r_tc : r_tr;
            r_min     <= w_horiz ? r_fr : r_fc;
            r_dmaj    <= w_horiz ? w_dc : w_dr;
            r_dmin    <= w_horiz ? w_dr : w_dc;
            r_maj_neg <= w_horiz ? w_c_neg : w_r_neg;
            r_min_neg <= w_horiz ? w_r_neg : w_c_neg;
            r_acc     <= '0;
        end else begin
            r_maj <= n_maj;
            r_min <= n_min;
            r_acc <= n_acc;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_visible <= r_res;
        end
    end

    // The error term stays below the major distance between steps.
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOOP || r_state == S_CHK2) && r_dmaj != '0)
            |-> (r_acc < {1'b0, r_dmaj}))
        else $error("walk error term reached the major distance");

    // The major axis is the longer one.
    a_major_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> (r_dmin <= r_dmaj))
        else $error("minor distance exceeds major distance");

    // Side-by-side cell checks happen only on straight lines.
    a_pair_straight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && (r_kind == K_PAIR_HI || r_kind == K_PAIR_LO))
            |-> (r_dmin == '0))
        else $error("pair check on a sloped line");

    // A result appears only after a query has finished its walk.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the final state");

endmodule

>>> design/glos_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/glos_cell_idx.sv
// Cell address unit: grid bounds check and linear map address of one cell.
module glos_cell_idx
    import glos_pkg::*;
#(
    parameter int GRID_H = 256,
    parameter int GRID_W = 256,
    parameter int AW = 16
) (
    input  t_cell           i_cell,
    output logic [AW-1:0]   o_addr,
    output logic            o_oob
);

    localparam int LIN_W = AW + COORD_W;
    localparam logic [LIM_W-1:0] LIM_ROWS = LIM_W'(GRID_H);
    localparam logic [LIM_W-1:0] LIM_COLS = LIM_W'(GRID_W);

    logic [LIM_W-1:0] w_row_u;
    logic [LIM_W-1:0] w_col_u;
    logic [LIN_W-1:0] w_lin;

    // Magnitudes of the coordinates; a set sign bit means the cell lies above or left of the grid.
    assign w_row_u = LIM_W'(i_cell.row[COORD_W-2:0]);
    assign w_col_u = LIM_W'(i_cell.col[COORD_W-2:0]);

    assign o_oob = i_cell.row[COORD_W-1] | i_cell.col[COORD_W-1]
                 | (w_row_u >= LIM_ROWS) | (w_col_u >= LIM_COLS);

    // Row-major address; meaningless when the cell is outside the grid.
    assign w_lin  = LIN_W'(w_row_u) * LIN_W'(GRID_W) + LIN_W'(w_col_u);
    assign o_addr = w_lin[AW-1:0];

endmodule
